// ----- rtl/lerdt_pkg.sv -----
// Shared constants, slot type and index helpers for the lossy event ring.
package lerdt_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] MAX_LINE_RESET = 16'd512;
    localparam logic [31:0] DROP_SAT       = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // One stored event descriptor
    typedef struct packed {
        logic [15:0] line_nbytes;
        logic [31:0] line_ref;
        logic [31:0] cmd_ident;
        logic [1:0]  correlation;
        logic [31:0] epoch;
        logic [31:0] seq_num;
        logic [47:0] timestamp;
        logic [31:0] drop_tag;
    } t_slot;

    // Advance a ring index with wrap
    function automatic logic [IDX_W-1:0] f_idx_inc(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
            return '0;
        return idx + IDX_W'(1);
    endfunction

    // Tail position: head plus count, modulo depth (count below depth)
    function automatic logic [IDX_W-1:0] f_tail(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, count[IDX_W-1:0]};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH))
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/lerdt_slot_mem.sv -----
// Slot storage: one write port, one read port with registered read data.
module lerdt_slot_mem
    import lerdt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot r_mem [QUEUE_DEPTH];
    t_slot r_rdata;

    // Write and read the slot array
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lossy_event_ring_with_drop_tags.sv -----
// Lossy event ring top level: control, drop accounting and result register.
// Enqueue and empty dequeue: result registered in the cycle after the input
// transfer; one per cycle while the output is not stalled.
// Dequeue of an entry: the slot memory read is registered, then the result is
// registered once the output is free; no new input is taken in between.
// Reset (synchronous, active low) clears head, count, drop totals, the limit
// register (to 512) and the handshakes; slot memory is not cleared.
module lossy_event_ring_with_drop_tags
    import lerdt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic [15:0]      i_line_nbytes,
    input  logic [31:0]      i_line_ref,
    input  logic [31:0]      i_cmd_ident,
    input  logic [1:0]       i_correlation,
    input  logic [31:0]      i_restart_epoch,
    input  logic [31:0]      i_line_sequence,
    input  logic [47:0]      i_timestamp_ms,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic             o_rejected,
    output logic [15:0]      o_out_line_nbytes,
    output logic [31:0]      o_out_line_ref,
    output logic [31:0]      o_out_cmd_ident,
    output logic [1:0]       o_out_correlation,
    output logic [31:0]      o_out_epoch,
    output logic [31:0]      o_out_sequence,
    output logic [47:0]      o_out_timestamp,
    output logic [31:0]      o_out_drop_tag,
    output logic [CNT_W-1:0] o_fill_level
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic             r_state,     n_state;
    logic [15:0]      r_max_line;
    logic [IDX_W-1:0] r_head,      n_head;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [31:0]      r_drop,      n_drop;
    logic [31:0]      r_pend,      n_pend;
    // tag of the head entry after an overflow, held outside the memory
    logic             r_ovr_valid, n_ovr_valid;
    logic [31:0]      r_ovr_tag,   n_ovr_tag;

    logic             r_out_valid, n_out_valid;
    logic             r_found,     n_found;
    logic             r_rejected,  n_rejected;
    t_slot            r_res,       n_res;
    logic [CNT_W-1:0] r_fill,      n_fill;

    logic             accept;
    logic             out_free;
    logic             full;
    logic [31:0]      drop_sat;
    logic [31:0]      head_tag;
    t_slot            wr_slot;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    t_slot            rd_slot;

    lerdt_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_slot),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (rd_slot)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign drop_sat   = (r_drop == DROP_SAT) ? r_drop : r_drop + 32'd1;
    assign head_tag   = r_ovr_valid ? r_ovr_tag : rd_slot.drop_tag;

    // Build the slot written by an enqueue
    always_comb begin
        wr_slot.line_nbytes = i_line_nbytes;
        wr_slot.line_ref    = i_line_ref;
        wr_slot.cmd_ident   = i_cmd_ident;
        wr_slot.correlation = i_correlation;
        wr_slot.epoch       = i_restart_epoch;
        wr_slot.seq_num     = i_line_sequence;
        wr_slot.timestamp   = i_timestamp_ms;
        wr_slot.drop_tag    = full ? 32'd0 : r_pend;
    end

    assign mem_we    = accept && (i_operation == OP_ENQ) && (i_line_nbytes < r_max_line);
    assign mem_waddr = full ? r_head : f_tail(r_head, r_count);
    assign mem_re    = accept && (i_operation == OP_DEQ) && (r_count != '0);

    // Sequence the item and update ring state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_drop      = r_drop;
        n_pend      = r_pend;
        n_ovr_valid = r_ovr_valid;
        n_ovr_tag   = r_ovr_tag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_rejected  = r_rejected;
        n_res       = r_res;
        n_fill      = r_fill;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ENQ) begin
                        n_out_valid = 1'b1;
                        n_found     = 1'b0;
                        n_res       = '0;
                        n_rejected  = 1'b0;
                        if (i_line_nbytes >= r_max_line) begin
                            // reject: count it as a drop
                            n_rejected = 1'b1;
                            n_drop     = drop_sat;
                            n_pend     = drop_sat;
                        end else if (full) begin
                            // overflow: drop oldest, tag the new oldest
                            n_head      = f_idx_inc(r_head);
                            n_drop      = drop_sat;
                            n_pend      = drop_sat;
                            n_ovr_valid = 1'b1;
                            n_ovr_tag   = drop_sat;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_pend  = 32'd0;
                        end
                        n_fill = n_count;
                    end else if (r_count == '0) begin
                        // empty dequeue
                        n_out_valid = 1'b1;
                        n_found     = 1'b0;
                        n_rejected  = 1'b0;
                        n_res       = '0;
                        n_fill      = '0;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state          = S_IDLE;
                    n_out_valid      = 1'b1;
                    n_found          = 1'b1;
                    n_rejected       = 1'b0;
                    n_res            = rd_slot;
                    n_res.drop_tag   = head_tag;
                    n_head           = f_idx_inc(r_head);
                    n_count          = r_count - CNT_W'(1);
                    n_fill           = n_count;
                    n_ovr_valid      = 1'b0;
                    if (head_tag != 32'd0 && head_tag == r_drop)
                        n_pend = 32'd0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_line  <= MAX_LINE_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_drop      <= '0;
            r_pend      <= '0;
            r_ovr_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_pend      <= n_pend;
            r_ovr_valid <= n_ovr_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we)
                r_max_line <= i_cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ovr_tag  <= n_ovr_tag;
        r_found    <= n_found;
        r_rejected <= n_rejected;
        r_res      <= n_res;
        r_fill     <= n_fill;
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_rejected        = r_rejected;
    assign o_out_line_nbytes = r_res.line_nbytes;
    assign o_out_line_ref    = r_res.line_ref;
    assign o_out_cmd_ident   = r_res.cmd_ident;
    assign o_out_correlation = r_res.correlation;
    assign o_out_epoch       = r_res.epoch;
    assign o_out_sequence    = r_res.seq_num;
    assign o_out_timestamp   = r_res.timestamp;
    assign o_out_drop_tag    = r_res.drop_tag;
    assign o_fill_level      = r_fill;

    // Ring never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    // A memory read is only in flight for a non-empty ring
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count != '0))
        else $error("dequeue read with empty ring");

    // The head tag override only exists while the ring is full
    a_ovr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovr_valid |-> (r_count == CNT_W'(QUEUE_DEPTH)))
        else $error("head tag override without full ring");

    // A result is never both found and rejected
    a_found_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_rejected))
        else $error("result both found and rejected");

endmodule
